// ===== hdl/persp_pkg.sv =====
// Shared constants and register codes for the perspective projection block.
package persp_pkg;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 63;
	localparam int TAN_BITS       = 24;
	localparam int SIZE_BITS      = 15;
	localparam int TA_BITS        = 32;
	localparam int TA_FRAC        = 16;
	localparam int AXIS_FRAC      = 19;
	localparam int NUM_SHIFT      = 23;
	localparam int QUO_BITS       = 33;
	localparam int OUT_BITS       = 32;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CAM_ORIGIN    = 3'd0,
		REG_RIGHT_AXIS    = 3'd1,
		REG_UP_AXIS       = 3'd2,
		REG_VIEW_AXIS     = 3'd3,
		REG_TAN_HALF_FOV  = 3'd4,
		REG_ASPECT_RATIO  = 3'd5,
		REG_SCREEN_WIDTH  = 3'd6,
		REG_SCREEN_HEIGHT = 3'd7
	} cfg_reg_t;

	localparam logic [CFG_DATA_BITS-1:0] CAM_ORIGIN_RST = 63'h0;
	localparam logic [CFG_DATA_BITS-1:0] RIGHT_AXIS_RST = 63'h0000_0000_0008_0000;
	localparam logic [CFG_DATA_BITS-1:0] UP_AXIS_RST    = 63'h0000_0100_0000_0000;
	localparam logic [CFG_DATA_BITS-1:0] VIEW_AXIS_RST  = 63'h7FFF_FC00_0000_0000;
	localparam logic [TAN_BITS-1:0]      TAN_RST        = 24'd27146;
	localparam logic [TAN_BITS-1:0]      ASPECT_RST     = 24'd116508;
	localparam logic [SIZE_BITS-1:0]     WIDTH_RST      = 15'd1920;
	localparam logic [SIZE_BITS-1:0]     HEIGHT_RST     = 15'd1080;
	// (TAN_RST * ASPECT_RST) >> TA_FRAC
	localparam logic [TA_BITS-1:0]       TA_RST         = 32'd48259;

endpackage

// ===== hdl/perspective_point_projection.sv =====
// Pipelined pinhole projection of world points to pixel coordinates.
//
// Usage:
//   Load camera origin, right/up/view axes, tan(fov/2), aspect ratio and the
//   screen size through the write port (cfg_wen, cfg_index, cfg_data) while
//   no beat is in flight. The product of tan_half_fov and aspect_ratio is
//   held in a register updated in the cycle after a write, before any new
//   point reaches the stage that reads it, so no idle gap is needed.
//   Points enter on item_valid/item_ready; one beat is world_x/y/z (Q11.10)
//   plus flip_y. Results leave on result_valid/result_ready as screen_x,
//   screen_y (Q24.8) and the saturated flag.
// Pipeline: 39 register stages: five arithmetic stages (difference, axis
//   products, dot sums, magnitude products, divide setup), 33 restoring
//   divide steps (one quotient bit a stage, both axes side by side) and the
//   clamp/output stage.
// Throughput: one point per cycle while the receiver takes results; each stage holds one item.
// Stall: every stage advances when it is empty or the next one advances, so
//   a stalled receiver fills the bubbles first and only then drops
//   item_ready; nothing is lost or repeated.
// Reset: arst_n clears all valid bits and restores the register defaults.
module perspective_point_projection #(
	parameter int COORD_BITS = 21
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wen,
	input  logic [persp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [persp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic signed [20:0]                    world_x,
	input  logic signed [20:0]                    world_y,
	input  logic signed [20:0]                    world_z,
	input  logic                                  flip_y,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic signed [persp_pkg::OUT_BITS-1:0] screen_x,
	output logic signed [persp_pkg::OUT_BITS-1:0] screen_y,
	output logic                                  saturated
);

	localparam int N    = COORD_BITS;
	localparam int DW   = N + 1;                       // point minus origin
	localparam int PW   = DW + N;                      // one axis product
	localparam int SW   = PW + 2;                      // sum of three
	localparam int CW   = SW - persp_pkg::AXIS_FRAC;   // camera coordinate
	localparam int NP   = persp_pkg::SIZE_BITS + CW;   // size * |c|
	localparam int DENW = CW + persp_pkg::TA_BITS;     // |cz| * k
	localparam int QB   = persp_pkg::QUO_BITS;
	localparam int HS   = QB - persp_pkg::NUM_SHIFT;   // shift of prod giving num >> QB
	localparam int VW   = QB + 2;                      // base +/- quotient

	typedef struct packed {
		logic [DENW-1:0] den;
		logic [DENW-1:0] rem;
		logic [QB-1:0]   low;
		logic [QB-1:0]   quo;
		logic            neg;
		logic            big;
		logic            dz;
	} lane_t;

	// configuration registers
	logic [persp_pkg::CFG_DATA_BITS-1:0] origin_q, right_q, up_q, view_q;
	logic [persp_pkg::TAN_BITS-1:0]      tan_q, aspect_q;
	logic [persp_pkg::SIZE_BITS-1:0]     width_q, height_q;
	logic [persp_pkg::TA_BITS-1:0]       ta_q;
	logic [2*persp_pkg::TAN_BITS-1:0]    ta_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= persp_pkg::CAM_ORIGIN_RST;
			right_q  <= persp_pkg::RIGHT_AXIS_RST;
			up_q     <= persp_pkg::UP_AXIS_RST;
			view_q   <= persp_pkg::VIEW_AXIS_RST;
			tan_q    <= persp_pkg::TAN_RST;
			aspect_q <= persp_pkg::ASPECT_RST;
			width_q  <= persp_pkg::WIDTH_RST;
			height_q <= persp_pkg::HEIGHT_RST;
		end else if (cfg_wen) begin
			unique case (persp_pkg::cfg_reg_t'(cfg_index))
				persp_pkg::REG_CAM_ORIGIN:    origin_q <= cfg_data;
				persp_pkg::REG_RIGHT_AXIS:    right_q  <= cfg_data;
				persp_pkg::REG_UP_AXIS:       up_q     <= cfg_data;
				persp_pkg::REG_VIEW_AXIS:     view_q   <= cfg_data;
				persp_pkg::REG_TAN_HALF_FOV:  tan_q    <= cfg_data[persp_pkg::TAN_BITS-1:0];
				persp_pkg::REG_ASPECT_RATIO:  aspect_q <= cfg_data[persp_pkg::TAN_BITS-1:0];
				persp_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_data[persp_pkg::SIZE_BITS-1:0];
				persp_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_data[persp_pkg::SIZE_BITS-1:0];
			endcase
		end
	end

	// tan * aspect in Q.16, kept in a register off the item path
	assign ta_full = (2*persp_pkg::TAN_BITS)'(tan_q) * (2*persp_pkg::TAN_BITS)'(aspect_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ta_q <= persp_pkg::TA_RST;
		end else begin
			ta_q <= ta_full[persp_pkg::TA_FRAC +: persp_pkg::TA_BITS];
		end
	end

	// packed register components, taken as signed fields at the stride N
	logic signed [N-1:0] org_c [3];
	logic signed [N-1:0] ax_c  [3][3];   // [axis][component]
	logic signed [N-1:0] pt_c  [3];

	assign pt_c[0] = world_x[N-1:0];
	assign pt_c[1] = world_y[N-1:0];
	assign pt_c[2] = world_z[N-1:0];

	for (genvar i = 0; i < 3; i++) begin : g_comp
		assign org_c[i]    = origin_q[i*N +: N];
		assign ax_c[0][i]  = right_q[i*N +: N];
		assign ax_c[1][i]  = up_q[i*N +: N];
		assign ax_c[2][i]  = view_q[i*N +: N];
	end

	// flow control: a stage moves when it is empty or the next one moves
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s39;
	logic en_div [QB];
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s39;
	logic v_s6 [QB];

	assign en_s39 = !v_s39 || result_ready;
	assign en_div[QB-1] = !v_s6[QB-1] || en_s39;
	for (genvar j = 0; j < QB-1; j++) begin : g_en
		assign en_div[j] = !v_s6[j] || en_div[j+1];
	end
	assign en_s5 = !v_s5 || en_div[0];
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign item_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s39 <= 1'b0;
		end else begin
			if (en_s1)  v_s1  <= item_valid;
			if (en_s2)  v_s2  <= v_s1;
			if (en_s3)  v_s3  <= v_s2;
			if (en_s4)  v_s4  <= v_s3;
			if (en_s5)  v_s5  <= v_s4;
			if (en_s39) v_s39 <= v_s6[QB-1];
		end
	end

	// stage 1: point minus camera origin
	logic signed [DW-1:0] d_s1 [3];
	logic                 flip_s1, flip_s2, flip_s3, flip_s4, flip_s5;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DW'(pt_c[i]) - DW'(org_c[i]);
			end
			flip_s1 <= flip_y;
		end
	end

	// stage 2: nine axis products
	logic signed [PW-1:0] p_s2 [3][3];

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int a = 0; a < 3; a++) begin
				for (int i = 0; i < 3; i++) begin
					p_s2[a][i] <= PW'(d_s1[i]) * PW'(ax_c[a][i]);
				end
			end
			flip_s2 <= flip_s1;
		end
	end

	// stage 3: dot sums, floor shift back to Q.10
	logic signed [SW-1:0] dot [3];
	logic signed [CW-1:0] c_s3 [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dot[a] = SW'(p_s2[a][0]) + SW'(p_s2[a][1]) + SW'(p_s2[a][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int a = 0; a < 3; a++) begin
				c_s3[a] <= dot[a][SW-1:persp_pkg::AXIS_FRAC];
			end
			flip_s3 <= flip_s2;
		end
	end

	// stage 4: magnitudes, numerator and divisor products
	logic [CW-1:0]   mag [3];
	logic [NP-1:0]   nx_s4, ny_s4;
	logic [DENW-1:0] dx_s4, dy_s4;
	logic            negx_s4, negy_s4;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mag[a] = c_s3[a][CW-1] ? CW'(-c_s3[a]) : CW'(c_s3[a]);
		end
	end

	// with a zero scale factor the offset follows the numerator sign alone
	always_ff @(posedge clk) begin
		if (en_s4) begin
			nx_s4   <= NP'(width_q) * NP'(mag[0]);
			ny_s4   <= NP'(height_q) * NP'(mag[1]);
			dx_s4   <= DENW'(mag[2]) * DENW'(ta_q);
			dy_s4   <= DENW'(mag[2]) * DENW'(tan_q);
			negx_s4 <= c_s3[0][CW-1] ^ (c_s3[2][CW-1] & (ta_q != '0));
			negy_s4 <= c_s3[1][CW-1] ^ (c_s3[2][CW-1] & (tan_q != '0));
			flip_s4 <= flip_s3;
		end
	end

	// stage 5: divide setup; a quotient of 2^QB or more always clamps
	function automatic lane_t lane_init(logic [NP-1:0] prod, logic [DENW-1:0] den,
			logic neg);
		lane_t           l;
		logic [DENW-1:0] hi;
		hi     = DENW'(prod[NP-1:HS]);
		l.den  = den;
		l.neg  = neg;
		l.dz   = (den == '0);
		l.big  = l.dz ? (prod != '0) : (hi >= den);
		l.rem  = l.big ? '0 : hi;
		l.low  = {prod[HS-1:0], persp_pkg::NUM_SHIFT'(0)};
		l.quo  = '0;
		return l;
	endfunction

	// one restoring step: bring down quotient bit j; a zero divisor yields zero
	function automatic lane_t lane_step(lane_t l, int j);
		lane_t         r;
		logic [DENW:0] t;
		logic          ge;
		r  = l;
		t  = {l.rem, l.low[QB-1-j]};
		ge = !l.dz && (t >= {1'b0, l.den});
		r.rem = ge ? DENW'(t - {1'b0, l.den}) : DENW'(t);
		r.quo = {l.quo[QB-2:0], ge};
		return r;
	endfunction

	lane_t lx_s5, ly_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			lx_s5   <= lane_init(nx_s4, dx_s4, negx_s4);
			ly_s5   <= lane_init(ny_s4, dy_s4, negy_s4);
			flip_s5 <= flip_s4;
		end
	end

	// stages 6 to 38: divide steps, one quotient bit per stage on both axes
	lane_t lx_s6 [QB];
	lane_t ly_s6 [QB];
	logic  flip_s6 [QB];

	for (genvar j = 0; j < QB; j++) begin : g_div
		lane_t px, py;
		logic  pv, pf;
		if (j == 0) begin : g_first
			assign px = lx_s5;
			assign py = ly_s5;
			assign pv = v_s5;
			assign pf = flip_s5;
		end else begin : g_next
			assign px = lx_s6[j-1];
			assign py = ly_s6[j-1];
			assign pv = v_s6[j-1];
			assign pf = flip_s6[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s6[j] <= 1'b0;
			end else if (en_div[j]) begin
				v_s6[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en_div[j]) begin
				lx_s6[j]   <= lane_step(px, j);
				ly_s6[j]   <= lane_step(py, j);
				flip_s6[j] <= pf;
			end
		end
	end

	// stage 39: recenter, mirror and clamp to 32 bits
	localparam logic signed [VW-1:0] MAX_V = VW'(64'sd2147483647);
	localparam logic signed [VW-1:0] MIN_V = -VW'(64'sd2147483648);

	function automatic logic [persp_pkg::OUT_BITS:0] place(
			logic [persp_pkg::SIZE_BITS-1:0] size, logic [QB-1:0] q, logic neg, logic big);
		logic signed [VW-1:0]         base;
		logic signed [VW-1:0]         v;
		logic signed [persp_pkg::OUT_BITS-1:0] o;
		logic                         sat;
		base = VW'({size, 7'b0});
		v    = neg ? base - VW'(q) : base + VW'(q);
		sat  = 1'b1;
		if (big) begin
			o = neg ? persp_pkg::OUT_BITS'(MIN_V) : persp_pkg::OUT_BITS'(MAX_V);
		end else if (v > MAX_V) begin
			o = persp_pkg::OUT_BITS'(MAX_V);
		end else if (v < MIN_V) begin
			o = persp_pkg::OUT_BITS'(MIN_V);
		end else begin
			o   = persp_pkg::OUT_BITS'(v);
			sat = 1'b0;
		end
		return {sat, o};
	endfunction

	lane_t                          fx, fy;
	logic [persp_pkg::OUT_BITS:0]   px_res, py_res;

	assign fx     = lx_s6[QB-1];
	assign fy     = ly_s6[QB-1];
	assign px_res = place(width_q, fx.quo, fx.neg, fx.big);
	assign py_res = place(height_q, fy.quo, fy.neg ^ flip_s6[QB-1], fy.big);

	logic signed [persp_pkg::OUT_BITS-1:0] sx_s39, sy_s39;
	logic                                  sat_s39;

	always_ff @(posedge clk) begin
		if (en_s39) begin
			sx_s39  <= px_res[persp_pkg::OUT_BITS-1:0];
			sy_s39  <= py_res[persp_pkg::OUT_BITS-1:0];
			sat_s39 <= px_res[persp_pkg::OUT_BITS] | py_res[persp_pkg::OUT_BITS]
				| fx.dz | fy.dz;
		end
	end

	assign result_valid = v_s39;
	assign screen_x     = sx_s39;
	assign screen_y     = sy_s39;
	assign saturated    = sat_s39;

`ifndef SYNTHESIS
	// a free receiver never blocks the sender
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> item_ready)
		else $error("item_ready low while result side is free");

	// divide remainders stay below their divisor
	a_rem_x: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6[QB-1] && !fx.dz) |-> (fx.rem < fx.den))
		else $error("x remainder out of range");

	a_rem_y: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6[QB-1] && !fy.dz) |-> (fy.rem < fy.den))
		else $error("y remainder out of range");

	// an overflowed quotient must raise the flag
	a_big_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6[QB-1] && en_s39 && (fx.big || fy.big)) |=> saturated)
		else $error("clamped result without saturated flag");
`endif

endmodule
